[rtl/pss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pss_pkg: shared types and constants of the physics substep scheduler
// Sequencer states, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned FRAME_W    = 32;
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned PROD_W     = STEP_W + COUNT_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_VARIABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SUBSTEPS  = 3'd4;

  // Reset values (1/80 s and 1/40 s in 2^-24 s units)
  localparam logic               RST_MODE_VARIABLE = 1'b1;
  localparam logic [STEP_W-1:0]  RST_FIXED_STEP    = 32'd209715;
  localparam logic [STEP_W-1:0]  RST_MIN_STEP      = 32'd209715;
  localparam logic [STEP_W-1:0]  RST_MAX_STEP      = 32'd419430;
  localparam logic [COUNT_W-1:0] RST_MAX_SUBSTEPS  = 8'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_CHECK,
    ST_DIV_COUNT,
    ST_COUNT,
    ST_DIV_LEN,
    ST_LENGTH,
    ST_MULT,
    ST_SUB,
    ST_DONE
  } pss_state_t;

endpackage
`default_nettype wire

[rtl/pss_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pss_div: iterative restoring divider
// One quotient bit per cycle; done pulses for one cycle with the last bit.
// ----------------------------------------------------------------------------
module pss_div #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);

  localparam int unsigned CNT_W = $clog2(W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     quo_r;
  logic [W-1:0]     dvs_r;

  logic [W:0]       trial;
  logic             fits;
  logic [W-1:0]     rem_nxt;
  logic [W-1:0]     quo_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[W-1]};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? W'(trial - {1'b0, dvs_r}) : trial[W-1:0];
    quo_nxt = {quo_r[W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

[rtl/physics_substep_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// physics_substep_scheduler: fixed timestep accumulator
// Turns per-frame elapsed time into a substep count and substep length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, in_frame_time) takes one frame time per
//   transfer. The result channel (out_valid/out_ready) returns one transfer of
//   out_substep_count and out_substep_length per input, in order.
//   Configuration registers are written through cfg_wr_en/cfg_index/
//   cfg_wr_data; the user must write them only while the block is idle, as
//   the block has no check for it. They take effect on the next frame.
//   One shared restoring divider produces one quotient bit per cycle. A frame
//   runs accumulate, threshold check, the count division, and in variable mode
//   the length division, then multiply and subtract; the divider width is
//   W = max(TIME_BITS, 32). Below the threshold the frame goes straight from
//   the check to the result, and a zero count skips the remaining steps.
//   in_ready returns in the cycle after the result loads, so a new frame is
//   accepted only once the previous one has loaded its result.
// Reset and stalls:
//   Reset clears the accumulator and loads the default register values. The
//   output register holds a result while out_ready is low; the next frame is
//   accepted meanwhile and waits in the final state until the slot frees.
// ----------------------------------------------------------------------------
module physics_substep_scheduler #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_wr_en,
  input  wire logic [pss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pss_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  // frame time input
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [pss_pkg::FRAME_W-1:0]    in_frame_time,
  // substep result
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [pss_pkg::COUNT_W-1:0]         out_substep_count,
  output logic [pss_pkg::STEP_W-1:0]          out_substep_length
);

  localparam int unsigned STEP_W  = pss_pkg::STEP_W;
  localparam int unsigned COUNT_W = pss_pkg::COUNT_W;
  localparam int unsigned FRAME_W = pss_pkg::FRAME_W;
  localparam int unsigned PROD_W  = pss_pkg::PROD_W;
  localparam int unsigned W       = (TIME_BITS > STEP_W) ? TIME_BITS : STEP_W;
  localparam int unsigned PW      = (TIME_BITS > pss_pkg::PROD_W) ? TIME_BITS
                                                                  : pss_pkg::PROD_W;
  localparam logic [W:0]  TIME_MAX = (W+1)'({TIME_BITS{1'b1}});

  // configuration registers
  logic                 mode_variable_r;
  logic [STEP_W-1:0]    fixed_step_r;
  logic [STEP_W-1:0]    min_step_r;
  logic [STEP_W-1:0]    max_step_r;
  logic [COUNT_W-1:0]   max_substeps_r;

  // sequencer and datapath
  pss_pkg::pss_state_t  state_r, state_nxt;
  logic [TIME_BITS-1:0] acc_r, acc_nxt;
  logic [FRAME_W-1:0]   ft_r;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [STEP_W-1:0]    len_r, len_nxt;
  logic [pss_pkg::PROD_W-1:0] prod_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]   out_count_r;
  logic [STEP_W-1:0]    out_len_r;
  logic                 out_load;

  // step selection
  logic [STEP_W-1:0]    step_raw;
  logic [STEP_W-1:0]    step;
  logic [STEP_W-1:0]    threshold;
  logic [W-1:0]         step_w;

  // accumulate
  logic [W-1:0]         acc_base;
  logic [W:0]           acc_sum;

  // count forming
  logic [W:0]           count_full;

  // divider
  logic                 div_start;
  logic [W-1:0]         div_divisor;
  logic                 div_done;
  logic [W-1:0]         div_quo;
  logic [W-1:0]         div_rem;

  logic [PW-1:0]        acc_diff;

  always_comb begin
    step_raw  = mode_variable_r ? max_step_r : fixed_step_r;
    step      = (step_raw == '0) ? STEP_W'(1) : step_raw;
    threshold = mode_variable_r ? min_step_r : step;
    step_w    = W'(step);
  end

  // Clear on overrun, then add with saturation at the accumulator width.
  always_comb begin
    acc_base = (W'(acc_r) > step_w) ? '0 : W'(acc_r);
    acc_sum  = (W+1)'(acc_base) + (W+1)'(ft_r);
    if (acc_sum > TIME_MAX) begin
      acc_sum = TIME_MAX;
    end
  end

  // Round up in variable mode when the division leaves a remainder.
  always_comb begin
    count_full = (W+1)'(div_quo)
               + (W+1)'(mode_variable_r && (div_rem != '0));
  end

  assign acc_diff = PW'(acc_r) - PW'(prod_r);

  // -------------------------------------------------------------------------
  // Configuration writes
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_variable_r <= pss_pkg::RST_MODE_VARIABLE;
      fixed_step_r    <= pss_pkg::RST_FIXED_STEP;
      min_step_r      <= pss_pkg::RST_MIN_STEP;
      max_step_r      <= pss_pkg::RST_MAX_STEP;
      max_substeps_r  <= pss_pkg::RST_MAX_SUBSTEPS;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pss_pkg::CFG_MODE_VARIABLE: mode_variable_r <= cfg_wr_data[0];
        pss_pkg::CFG_FIXED_STEP:    fixed_step_r    <= cfg_wr_data[STEP_W-1:0];
        pss_pkg::CFG_MIN_STEP:      min_step_r      <= cfg_wr_data[STEP_W-1:0];
        pss_pkg::CFG_MAX_STEP:      max_step_r      <= cfg_wr_data[STEP_W-1:0];
        pss_pkg::CFG_MAX_SUBSTEPS:  max_substeps_r  <= cfg_wr_data[COUNT_W-1:0];
        default: begin
          // drop writes past the register list
        end
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer: next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pss_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = pss_pkg::ST_ACCUM;
        end
      end
      pss_pkg::ST_ACCUM: begin
        state_nxt = pss_pkg::ST_CHECK;
      end
      pss_pkg::ST_CHECK: begin
        state_nxt = (W'(acc_r) < W'(threshold)) ? pss_pkg::ST_DONE
                                                : pss_pkg::ST_DIV_COUNT;
      end
      pss_pkg::ST_DIV_COUNT: begin
        if (div_done) begin
          state_nxt = pss_pkg::ST_COUNT;
        end
      end
      pss_pkg::ST_COUNT: begin
        priority if (count_nxt == '0) begin
          state_nxt = pss_pkg::ST_DONE;
        end else if (mode_variable_r) begin
          state_nxt = pss_pkg::ST_DIV_LEN;
        end else begin
          state_nxt = pss_pkg::ST_MULT;
        end
      end
      pss_pkg::ST_DIV_LEN: begin
        if (div_done) begin
          state_nxt = pss_pkg::ST_LENGTH;
        end
      end
      pss_pkg::ST_LENGTH: begin
        state_nxt = pss_pkg::ST_MULT;
      end
      pss_pkg::ST_MULT: begin
        state_nxt = pss_pkg::ST_SUB;
      end
      pss_pkg::ST_SUB: begin
        state_nxt = pss_pkg::ST_DONE;
      end
      pss_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = pss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pss_pkg::ST_IDLE;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Sequencer: outputs and datapath next values
  // -------------------------------------------------------------------------
  always_comb begin
    in_ready      = (state_r == pss_pkg::ST_IDLE);
    div_start     = 1'b0;
    div_divisor   = step_w;
    acc_nxt       = acc_r;
    count_nxt     = count_r;
    len_nxt       = len_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      pss_pkg::ST_ACCUM: begin
        acc_nxt = acc_sum[TIME_BITS-1:0];
      end
      pss_pkg::ST_CHECK: begin
        // start count division, or answer zero below the threshold
        count_nxt = '0;
        len_nxt   = '0;
        if (W'(acc_r) >= W'(threshold)) begin
          div_start = 1'b1;
        end
      end
      pss_pkg::ST_COUNT: begin
        // cap the count, then divide the accumulator by it in variable mode
        count_nxt = (count_full > (W+1)'(max_substeps_r)) ? max_substeps_r
                                                           : count_full[COUNT_W-1:0];
        len_nxt   = (count_nxt == '0) ? '0 : step;
        div_divisor = W'(count_nxt);
        if ((count_nxt != '0) && mode_variable_r) begin
          div_start = 1'b1;
        end
      end
      pss_pkg::ST_LENGTH: begin
        len_nxt = (div_quo > step_w) ? step : div_quo[STEP_W-1:0];
      end
      pss_pkg::ST_SUB: begin
        acc_nxt = acc_diff[TIME_BITS-1:0];
      end
      pss_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        // hold
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pss_pkg::ST_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ft_r <= in_frame_time;
    end
    count_r <= count_nxt;
    len_r   <= len_nxt;
    if (state_r == pss_pkg::ST_MULT) begin
      prod_r <= PROD_W'(count_r) * PROD_W'(len_r);
    end
    if (out_load) begin
      out_count_r <= count_r;
      out_len_r   <= len_r;
    end
  end

  // -------------------------------------------------------------------------
  // Shared divider: accumulator / step, then accumulator / count
  // -------------------------------------------------------------------------
  pss_div #(
    .W (W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (W'(acc_r)),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign out_valid          = out_valid_r;
  assign out_substep_count  = out_count_r;
  assign out_substep_length = out_len_r;

endmodule
`default_nettype wire
